>>> design/smm_pkg.sv
// Shared types and constants for the matrix multiply core.
// No dependencies; used by smm_mac.sv and strassen_matrix_multiply_core.sv.
package smm_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned ADDR_W  = 6;
    localparam int unsigned DEPTH   = 64;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_first;
    } mac_ctrl_t;

endpackage

>>> design/smm_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, then accumulate.
// Depends on smm_pkg.
module smm_mac (
    input  logic                                aclk,
    input  smm_pkg::mac_ctrl_t                  ctrl,
    input  logic [smm_pkg::DATA_W-1:0]          op_a,
    input  logic [smm_pkg::DATA_W-1:0]          op_b,
    output logic [smm_pkg::DATA_W-1:0]          sum
);
    logic [smm_pkg::DATA_W-1:0] prod_reg;
    logic [smm_pkg::DATA_W-1:0] acc_reg;
    logic [2*smm_pkg::DATA_W-1:0] prod_full;

    assign prod_full = op_a * op_b;
    // Start a fresh sum on the first term of each dot product.
    assign sum = (ctrl.acc_first ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_full[smm_pkg::DATA_W-1:0];
        end
        if (ctrl.acc_en) begin
            acc_reg <= sum;
        end
    end
endmodule

>>> design/strassen_matrix_multiply_core.sv
// Top level of the square integer matrix multiply core.
// Depends on smm_pkg and smm_mac.
//
// Usage: send element pairs (A, B at the same position) on the s_ channel in
// row-major order, one request per cycle while s_tready is high. The side is
// 2^dim_log2 (clamped to MAX_DIM), written through cfg_wr_en/cfg_wr_data
// while idle; a write also discards any partly loaded matrix.
// After the final pair the core stops taking requests and computes the
// product with one shared multiplier and accumulator: each product element
// is a dot product of side terms, each term passing through memory read,
// multiply and accumulate. Elements leave on the m_ channel in row-major
// order with row, column and tlast on the final one. The single multiplier
// sets the compute time, and each element also waits for its output
// handshake. Load rate is one pair per cycle.
// A stalled receiver holds the current result and the core waits.
// Reset (aresetn low, synchronous) returns to loading with an empty matrix
// and dim_log2 = 3; the element memories are not cleared.
module strassen_matrix_multiply_core #(
    parameter int unsigned MAX_DIM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,   // dim_log2
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // [31:0] a_value, [63:32] b_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // [31:0] c_value, [34:32] out_row,
                                       // [37:35] out_col, [39:38] zero
    output logic        m_tlast
);
    localparam int unsigned LG_MAX = $clog2(MAX_DIM + 1) - 1;

    localparam int unsigned DW = smm_pkg::DATA_W;
    localparam int unsigned IW = smm_pkg::IDX_W;
    localparam int unsigned AW = smm_pkg::ADDR_W;
    localparam int unsigned CW = smm_pkg::COUNT_W;

    smm_pkg::state_t state_reg, state_next;
    smm_pkg::mac_ctrl_t mac_ctrl;

    logic [1:0]    dim_reg;
    logic [1:0]    lg;
    logic [CW-1:0] load_count_reg;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] cells;
    logic [IW-1:0] side_m1;
    logic [IW-1:0] ci_reg, cj_reg, ck_reg;
    logic          load_done;
    logic          k_last, j_last, i_last;
    logic          s_fire, m_fire;

    logic [DW-1:0] a_mem [smm_pkg::DEPTH];
    logic [DW-1:0] b_mem [smm_pkg::DEPTH];
    logic [DW-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0] a_addr, b_addr;
    logic [DW-1:0] mac_sum;

    logic [DW-1:0] c_reg;
    logic [IW-1:0] row_reg, col_reg;
    logic          last_reg;

    // Clamp the side to the largest power of two within MAX_DIM.
    assign lg      = (dim_reg > 2'(LG_MAX)) ? 2'(LG_MAX) : dim_reg;
    assign cells   = CW'(1) << {lg, 1'b0};
    assign side_m1 = IW'((4'd1 << lg) - 4'd1);

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign count_inc = load_count_reg + CW'(1);
    assign load_done = (count_inc == cells);
    assign k_last    = (ck_reg == side_m1);
    assign j_last    = (cj_reg == side_m1);
    assign i_last    = (ci_reg == side_m1);

    assign a_addr = (AW'(ci_reg) << lg) | AW'(ck_reg);
    assign b_addr = (AW'(ck_reg) << lg) | AW'(cj_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smm_pkg::ST_LOAD: begin
                if (s_fire && load_done) begin
                    state_next = smm_pkg::ST_READ;
                end
            end
            smm_pkg::ST_READ: state_next = smm_pkg::ST_MUL;
            smm_pkg::ST_MUL:  state_next = smm_pkg::ST_ACC;
            smm_pkg::ST_ACC: begin
                state_next = k_last ? smm_pkg::ST_OUT : smm_pkg::ST_READ;
            end
            smm_pkg::ST_OUT: begin
                if (m_fire) begin
                    state_next = (last_reg) ? smm_pkg::ST_LOAD : smm_pkg::ST_READ;
                end
            end
            default: state_next = smm_pkg::ST_LOAD;
        endcase
    end

    // Outputs and unit control.
    always_comb begin
        s_tready          = 1'b0;
        m_tvalid          = 1'b0;
        mac_ctrl.mul_en    = 1'b0;
        mac_ctrl.acc_en    = 1'b0;
        mac_ctrl.acc_first = (ck_reg == '0);
        case (state_reg)
            smm_pkg::ST_LOAD: s_tready = 1'b1;
            smm_pkg::ST_MUL:  mac_ctrl.mul_en = 1'b1;
            smm_pkg::ST_ACC:  mac_ctrl.acc_en = 1'b1;
            smm_pkg::ST_OUT:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= smm_pkg::ST_LOAD;
            dim_reg        <= 2'd3;
            load_count_reg <= '0;
            ci_reg         <= '0;
            cj_reg         <= '0;
            ck_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                // Drop any partial matrix on a size write.
                dim_reg        <= cfg_wr_data;
                load_count_reg <= '0;
            end else if (s_fire) begin
                load_count_reg <= load_done ? '0 : count_inc;
            end
            if (s_fire && load_done) begin
                ci_reg <= '0;
                cj_reg <= '0;
                ck_reg <= '0;
            end
            if (state_reg == smm_pkg::ST_ACC) begin
                ck_reg <= k_last ? '0 : ck_reg + IW'(1);
            end
            if (m_fire) begin
                // Advance to the next element in row-major order.
                cj_reg <= j_last ? '0 : cj_reg + IW'(1);
                if (j_last) begin
                    ci_reg <= i_last ? '0 : ci_reg + IW'(1);
                end
            end
        end
    end

    // Element memories: write on load, registered read during compute.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_mem[load_count_reg[AW-1:0]] <= s_tdata[31:0];
            b_mem[load_count_reg[AW-1:0]] <= s_tdata[63:32];
        end
        rd_a_reg <= a_mem[a_addr];
        rd_b_reg <= b_mem[b_addr];
    end

    smm_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .op_a  (rd_a_reg),
        .op_b  (rd_b_reg),
        .sum   (mac_sum)
    );

    // Hold the finished element until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (state_reg == smm_pkg::ST_ACC && k_last) begin
            c_reg    <= mac_sum;
            row_reg  <= ci_reg;
            col_reg  <= cj_reg;
            last_reg <= i_last && j_last;
        end
    end

    assign m_tdata = {2'b00, col_reg, row_reg, c_reg};
    assign m_tlast = last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("load and output active together");

    a_last_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> s_tready)
        else $error("no return to loading after final element");

    a_final_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && load_done && !cfg_wr_en) |=> (!s_tready && load_count_reg == '0))
        else $error("final load did not start compute");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_count_reg < cells)
        else $error("load count beyond matrix size");
endmodule
